[rtl/gcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package gcs_pkg;

   // Field widths
   localparam int KIND_W = 3;
   localparam int CRD_W  = 8;
   localparam int VAL_W  = 8;
   localparam int SUM_W  = 11;
   localparam int STS_W  = 2;
   localparam int GSZ_W  = 7;

   // Stream packing: x, y, value in; cell_value, neighbour_sum, status out
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_PAD_W   = RSP_TDATA_W - VAL_W - SUM_W - STS_W;

   localparam logic [GSZ_W-1:0] GRID_SIZE_RESET = 7'd64;

   // Request kinds as they arrive on the bus
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SUM    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_STAGE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_COMMIT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_INVERT = 3'd5;

   // Result status codes
   localparam logic [STS_W-1:0] STS_OK   = 2'd0;
   localparam logic [STS_W-1:0] STS_OOB  = 2'd1;
   localparam logic [STS_W-1:0] STS_FULL = 2'd2;

   // Command queue between front and back
   localparam int CMDQ_DEPTH = 2;

   // Last of the eight neighbour slots
   localparam logic [2:0] NB_LAST_IDX = 3'd7;

   typedef enum logic [2:0] {
      OP_READ   = 3'd0,
      OP_SUM    = 3'd1,
      OP_STAGE  = 3'd2,
      OP_COMMIT = 3'd3,
      OP_WRITE  = 3'd4,
      OP_INVERT = 3'd5,
      OP_NONE   = 3'd6
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               ok;     // centre coordinate lies inside the active grid
      logic [CRD_W-1:0]   x;
      logic [CRD_W-1:0]   y;
      logic [VAL_W-1:0]   value;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

   typedef struct packed {
      logic clearing;
      logic done;
   } bk_stat_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC,
      BK_READ_DATA,
      BK_INV_WR,
      BK_NB,
      BK_NB_LAST,
      BK_CMT,
      BK_DONE
   } bk_state_type;

   // Signed 9-bit coordinates against the active size n
   function automatic logic grid_hit(input logic [CRD_W:0] r, input logic [CRD_W:0] c,
                                     input logic [CRD_W-1:0] n);
      grid_hit = !r[CRD_W] && !c[CRD_W] && (r < {1'b0, n}) && (c < {1'b0, n});
   endfunction

   // Neighbour offsets {dr, dc}, each two's complement in two bits
   function automatic logic [3:0] nb_delta(input logic [2:0] idx);
      logic [3:0] d;
      unique case (idx)
         3'd0: d = {2'b11, 2'b11};
         3'd1: d = {2'b11, 2'b00};
         3'd2: d = {2'b11, 2'b01};
         3'd3: d = {2'b00, 2'b11};
         3'd4: d = {2'b00, 2'b01};
         3'd5: d = {2'b01, 2'b11};
         3'd6: d = {2'b01, 2'b00};
         default: d = {2'b01, 2'b01};
      endcase
      nb_delta = d;
   endfunction

endpackage
`default_nettype wire

[rtl/gcs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module gcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[rtl/gcs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module gcs_front (
   input  wire logic [gcs_pkg::KIND_W-1:0] kind,
   input  wire logic [gcs_pkg::CRD_W-1:0]  x,
   input  wire logic [gcs_pkg::CRD_W-1:0]  y,
   input  wire logic [gcs_pkg::VAL_W-1:0]  value,
   input  wire logic [gcs_pkg::CRD_W-1:0]  n_act,
   output gcs_pkg::cmd_type                cmd
);
   import gcs_pkg::*;

   // Decode the kind and bounds-check the centre cell
   always_comb begin
      cmd.x     = x;
      cmd.y     = y;
      cmd.value = value;
      cmd.ok    = grid_hit({x[CRD_W-1], x}, {y[CRD_W-1], y}, n_act);
      unique case (kind)
         KIND_READ:   cmd.op = OP_READ;
         KIND_SUM:    cmd.op = OP_SUM;
         KIND_STAGE:  cmd.op = OP_STAGE;
         KIND_COMMIT: cmd.op = OP_COMMIT;
         KIND_WRITE:  cmd.op = OP_WRITE;
         KIND_INVERT: cmd.op = OP_INVERT;
         default:     cmd.op = OP_NONE;
      endcase
   end

endmodule
`default_nettype wire

[rtl/gcs_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
module gcs_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire gcs_pkg::cmd_type push_data,
   input  wire logic             pop,
   output gcs_pkg::cmd_type      pop_data,
   output gcs_pkg::fifo_stat_type stat
);
   import gcs_pkg::*;

   localparam int PTR_W = $clog2(CMDQ_DEPTH);

   cmd_type          slot_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      cnt_in    = cnt_ff + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
   end

   assign pop_data   = slot_ff[rd_ptr_ff];
   assign stat.empty = (cnt_ff == '0);
   assign stat.full  = (cnt_ff == (PTR_W + 1)'(CMDQ_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[rtl/gcs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module gcs_back #(
   parameter int GRID_DIM    = 64,
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [gcs_pkg::CRD_W-1:0]  n_act,
   input  wire logic                       head_valid,
   input  wire gcs_pkg::cmd_type           head,
   output logic                            pop,
   output gcs_pkg::bk_stat_type            stat,
   input  wire logic                       rsp_ready,
   output logic                            rsp_valid,
   output logic [gcs_pkg::VAL_W-1:0]       rsp_cell,
   output logic [gcs_pkg::SUM_W-1:0]       rsp_sum,
   output logic [gcs_pkg::STS_W-1:0]       rsp_status
);
   import gcs_pkg::*;

   localparam int IDX_W      = $clog2(GRID_DIM);
   localparam int CA_W       = 2 * IDX_W;
   localparam int CELL_DEPTH = 1 << CA_W;
   localparam int QA_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int QE_W       = CA_W + VAL_W;

   bk_state_type     state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [2:0]       nb_idx_ff, nb_idx_in;
   logic [CNT_W-1:0] cmt_idx_ff, cmt_idx_in;
   logic             pend_ff, pend_in;
   logic             pend_ok_ff, pend_ok_in;
   logic [VAL_W-1:0] cell_ff, cell_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [STS_W-1:0] status_ff, status_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CA_W-1:0]  clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic [STS_W-1:0] rsp_status_ff, rsp_status_in;

   logic             c_we;
   logic [CA_W-1:0]  c_waddr, c_raddr;
   logic [VAL_W-1:0] c_wdata, c_rdata;
   logic             q_we;
   logic [QA_W-1:0]  q_waddr, q_raddr;
   logic [QE_W-1:0]  q_wdata, q_rdata;

   logic [CA_W-1:0]  cmd_addr;
   logic [3:0]       nb_d;
   logic [CRD_W:0]   nb_r, nb_c;
   logic             nb_ok;
   logic [CA_W-1:0]  nb_addr;
   logic             q_ok;
   logic             q_full;
   logic             cmt_more;
   logic             out_free;

   gcs_ram #(.WIDTH(VAL_W), .DEPTH(CELL_DEPTH)) u_cell_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_addr (c_raddr),
      .rd_data (c_rdata)
   );

   gcs_ram #(.WIDTH(QE_W), .DEPTH(QUEUE_DEPTH)) u_stage_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   // Address and bounds helpers
   always_comb begin
      cmd_addr = {cmd_ff.x[IDX_W-1:0], cmd_ff.y[IDX_W-1:0]};
      nb_d     = nb_delta(nb_idx_ff);
      nb_r     = {cmd_ff.x[CRD_W-1], cmd_ff.x} + {{(CRD_W - 1){nb_d[3]}}, nb_d[3:2]};
      nb_c     = {cmd_ff.y[CRD_W-1], cmd_ff.y} + {{(CRD_W - 1){nb_d[1]}}, nb_d[1:0]};
      nb_ok    = grid_hit(nb_r, nb_c, n_act);
      nb_addr  = {nb_r[IDX_W-1:0], nb_c[IDX_W-1:0]};
      q_ok     = grid_hit((CRD_W + 1)'(q_rdata[CA_W-1:IDX_W]),
                          (CRD_W + 1)'(q_rdata[IDX_W-1:0]), n_act);
      q_full   = (cnt_ff >= CNT_W'(QUEUE_DEPTH));
      cmt_more = (cmt_idx_ff < cnt_ff);
      out_free = !rsp_valid_ff || rsp_ready;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (&clr_ff) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (head_valid) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            unique case (cmd_ff.op)
               OP_READ:   state_in = cmd_ff.ok ? BK_READ_DATA : BK_DONE;
               OP_SUM:    state_in = BK_NB;
               OP_COMMIT: state_in = BK_CMT;
               OP_INVERT: state_in = cmd_ff.ok ? BK_INV_WR : BK_DONE;
               default:   state_in = BK_DONE;
            endcase
         end
         BK_READ_DATA: state_in = BK_DONE;
         BK_INV_WR:    state_in = BK_DONE;
         BK_NB: begin
            if (nb_idx_ff == NB_LAST_IDX) begin
               state_in = BK_NB_LAST;
            end
         end
         BK_NB_LAST: state_in = BK_DONE;
         BK_CMT: begin
            if (!cmt_more) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      cmd_in        = cmd_ff;
      nb_idx_in     = nb_idx_ff;
      cmt_idx_in    = cmt_idx_ff;
      pend_in       = 1'b0;
      pend_ok_in    = pend_ok_ff;
      cell_in       = cell_ff;
      sum_in        = sum_ff;
      status_in     = status_ff;
      cnt_in        = cnt_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_cell_in   = rsp_cell_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      pop           = 1'b0;
      c_we          = 1'b0;
      c_waddr       = cmd_addr;
      c_wdata       = cmd_ff.value;
      c_raddr       = cmd_addr;
      q_we          = 1'b0;
      q_waddr       = cnt_ff[QA_W-1:0];
      q_wdata       = {cmd_ff.value, cmd_ff.x[IDX_W-1:0], cmd_ff.y[IDX_W-1:0]};
      q_raddr       = cmt_idx_ff[QA_W-1:0];

      unique case (state_ff)
         BK_CLEAR: begin
            c_we    = 1'b1;
            c_waddr = clr_ff;
            c_wdata = '0;
            clr_in  = clr_ff + CA_W'(1);
         end
         BK_IDLE: begin
            pop = head_valid;
            if (head_valid) begin
               cmd_in     = head;
               cell_in    = '0;
               sum_in     = '0;
               status_in  = STS_OK;
               nb_idx_in  = '0;
               cmt_idx_in = '0;
            end
         end
         BK_EXEC: begin
            unique case (cmd_ff.op)
               OP_READ, OP_INVERT: begin
                  if (!cmd_ff.ok) begin
                     status_in = STS_OOB;
                  end
               end
               OP_STAGE: begin
                  if (!cmd_ff.ok) begin
                     status_in = STS_OOB;
                  end else if (q_full) begin
                     status_in = STS_FULL;
                  end else begin
                     q_we   = 1'b1;
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
               end
               OP_WRITE: begin
                  if (cmd_ff.ok) begin
                     c_we = 1'b1;
                  end else begin
                     status_in = STS_OOB;
                  end
               end
               default: begin
               end
            endcase
         end
         BK_READ_DATA: cell_in = c_rdata;
         BK_INV_WR: begin
            c_we    = 1'b1;
            c_wdata = (c_rdata == VAL_W'(1)) ? '0 : VAL_W'(1);
         end
         BK_NB: begin
            c_raddr    = nb_addr;
            pend_in    = 1'b1;
            pend_ok_in = nb_ok;
            nb_idx_in  = nb_idx_ff + 3'd1;
            if (pend_ff && pend_ok_ff) begin
               sum_in = sum_ff + SUM_W'(c_rdata);
            end
         end
         BK_NB_LAST: begin
            if (pend_ff && pend_ok_ff) begin
               sum_in = sum_ff + SUM_W'(c_rdata);
            end
         end
         BK_CMT: begin
            // apply the entry read last cycle, skip it if the grid shrank
            if (pend_ff && q_ok) begin
               c_we    = 1'b1;
               c_waddr = q_rdata[CA_W-1:0];
               c_wdata = q_rdata[QE_W-1:CA_W];
            end
            if (cmt_more) begin
               pend_in    = 1'b1;
               cmt_idx_in = cmt_idx_ff + CNT_W'(1);
            end else begin
               cnt_in = '0;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cell_in   = cell_ff;
               rsp_sum_in    = sum_ff;
               rsp_status_in = status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      nb_idx_ff     <= nb_idx_in;
      cmt_idx_ff    <= cmt_idx_in;
      pend_ok_ff    <= pend_ok_in;
      cell_ff       <= cell_in;
      sum_ff        <= sum_in;
      status_ff     <= status_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign stat.clearing = (state_ff == BK_CLEAR);
   assign stat.done     = (state_ff == BK_DONE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell      = rsp_cell_ff;
   assign rsp_sum       = rsp_sum_ff;
   assign rsp_status    = rsp_status_ff;

endmodule
`default_nettype wire

[rtl/grid_cell_store_with_neighbour_sum.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tuser: kind; tdata: x, y, value
// rsp_      out  rsp_tvalid/rsp_tready  tdata: cell_value, neighbour_sum, status
// csr_      in   csr_we (no wait)       csr_wdata: grid_size
//
// Per request: read/invert out of grid skip the cell memory;
// write, stage and unused kinds act in the execute state; neighbour sum does eight reads
// on one read port; commit applies one staged entry per cycle.
// After reset a clearing pass zeroes the cell memory one cell a cycle:
// all 2**(2*clog2(GRID_DIM)) cells, 4096 at the default; requests queue but wait.
// A held result stalls the back; the two-entry queue accepts until it fills.
module grid_cell_store_with_neighbour_sum #(
   parameter int GRID_DIM    = 64,
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [gcs_pkg::REQ_TDATA_W-1:0]   req_tdata,   // x[7:0], y[15:8], value[23:16]
   input  wire logic [gcs_pkg::KIND_W-1:0]        req_tuser,   // kind[2:0]
   // result channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [gcs_pkg::RSP_TDATA_W-1:0]        rsp_tdata,   // cell_value[7:0],
                                                               // neighbour_sum[18:8],
                                                               // status[20:19], zero[23:21]
   // grid size register
   input  wire logic                              csr_we,
   input  wire logic [gcs_pkg::GSZ_W-1:0]         csr_wdata
);
   import gcs_pkg::*;

   logic [GSZ_W-1:0] grid_size_ff, grid_size_in;
   logic [CRD_W-1:0] n_act;

   cmd_type       front_cmd;
   cmd_type       head_cmd;
   fifo_stat_type fq_stat;
   bk_stat_type   bk_stat;
   logic          cmd_push;
   logic          cmd_pop;

   logic [VAL_W-1:0] rsp_cell;
   logic [SUM_W-1:0] rsp_sum;
   logic [STS_W-1:0] rsp_status;

   // Grid size register; load on csr_we, change it only while nothing is in flight
   assign grid_size_in = csr_we ? csr_wdata : grid_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= GRID_SIZE_RESET;
      end else begin
         grid_size_ff <= grid_size_in;
      end
   end

   // Clamp the active size to the physical grid
   assign n_act = ({1'b0, grid_size_ff} > CRD_W'(GRID_DIM)) ? CRD_W'(GRID_DIM)
                                                             : {1'b0, grid_size_ff};

   // Front: decode and bounds-check at acceptance
   gcs_front u_front (
      .kind  (req_tuser),
      .x     (req_tdata[CRD_W-1:0]),
      .y     (req_tdata[2*CRD_W-1:CRD_W]),
      .value (req_tdata[2*CRD_W+VAL_W-1:2*CRD_W]),
      .n_act (n_act),
      .cmd   (front_cmd)
   );

   assign req_tready = !fq_stat.full;
   assign cmd_push   = req_tvalid && req_tready;

   gcs_fifo u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (front_cmd),
      .pop       (cmd_pop),
      .pop_data  (head_cmd),
      .stat      (fq_stat)
   );

   // Back: sequence memory accesses and hold the result
   gcs_back #(.GRID_DIM(GRID_DIM), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .n_act      (n_act),
      .head_valid (!fq_stat.empty),
      .head       (head_cmd),
      .pop        (cmd_pop),
      .stat       (bk_stat),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_cell   (rsp_cell),
      .rsp_sum    (rsp_sum),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_status, rsp_sum, rsp_cell};

   // Nothing executes or answers during the clearing pass
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      bk_stat.clearing |-> !cmd_pop && !rsp_tvalid)
      else $error("command popped or result shown during clearing pass");

   // The back pops only a command that is really queued
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !fq_stat.empty)
      else $error("pop from empty command queue");

   // A new result appears only after the back finished a command
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(bk_stat.done))
      else $error("result raised without a finished command");

endmodule
`default_nettype wire
